[rtl/jan_pkg.sv]
// Types, constants and register codes for the joystick axis normalizer.
// No dependencies; every other file imports this package.
`default_nettype none
package jan_pkg;
	localparam int SAMPLE_BITS = 10;
	localparam int BAND_BITS = 7;
	localparam int QBITS = 7;
	localparam int MUL_W = SAMPLE_BITS + 7;
	localparam int AXIS_LAT = QBITS + 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [MUL_W-1:0] SCALE = MUL_W'(100);
	localparam logic [MUL_W-1:0] SAT_LIMIT = MUL_W'(101);
	localparam logic [QBITS-1:0] FULL_SCALE = QBITS'(100);

	localparam logic [4:0] DIR_UP = 5'b00001;
	localparam logic [4:0] DIR_DOWN = 5'b00010;
	localparam logic [4:0] DIR_LEFT = 5'b00100;
	localparam logic [4:0] DIR_RIGHT = 5'b01000;
	localparam logic [4:0] DIR_CENTER = 5'b10000;
	localparam logic [7:0] LED_BUTTON = 8'h80;

	localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(512);
	localparam logic [SAMPLE_BITS-1:0] MIN_RST = '0;
	localparam logic [SAMPLE_BITS-1:0] MAX_RST = SAMPLE_BITS'(1023);
	localparam logic [BAND_BITS-1:0] BAND_RST = BAND_BITS'(50);

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_MINIMUM_X = 3'd2,
		CFG_MAXIMUM_X = 3'd3,
		CFG_MINIMUM_Y = 3'd4,
		CFG_MAXIMUM_Y = 3'd5,
		CFG_DEAD_BAND = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		sample_t sample_x;
		sample_t sample_y;
		logic button_level;
	} in_item_t;

	typedef struct packed {
		logic signed [7:0] position_x;
		logic signed [7:0] position_y;
		logic [4:0] direction_mask;
		logic pressed;
		logic [7:0] led_pattern;
	} out_item_t;

	// Per-axis quotient: magnitude is valid only when neither sat nor zero is set
	typedef struct packed {
		logic sat;
		logic neg;
		logic zero;
		logic [QBITS-1:0] mag;
	} axis_res_t;
endpackage
`default_nettype wire

[rtl/jan_axis.sv]
// One axis: center offset, span select, x100 scale and a restoring quotient
// pipeline, one quotient bit per stage. Depends on jan_pkg.
`default_nettype none
module jan_axis (
	input wire logic clk,
	input wire logic en,
	input wire jan_pkg::sample_t sample,
	input wire jan_pkg::sample_t center,
	input wire jan_pkg::sample_t lo,
	input wire jan_pkg::sample_t hi,
	output jan_pkg::axis_res_t res
);
	import jan_pkg::*;

	logic signed [SAMPLE_BITS:0] off;
	logic signed [SAMPLE_BITS:0] span;
	logic signed [SAMPLE_BITS:0] off_abs;
	logic signed [SAMPLE_BITS:0] span_abs;

	logic [SAMPLE_BITS-1:0] off_mag_s1;
	logic [SAMPLE_BITS-1:0] span_mag_s1;
	logic neg_s1, zero_s1, zspan_s1;

	logic [MUL_W-1:0] num_s2;
	logic [MUL_W-1:0] lim_s2;
	logic [SAMPLE_BITS-1:0] den_s2;
	logic neg_s2, zero_s2, zspan_s2;

	// index 0 is the third stage, index k+1 follows quotient step k
	logic [MUL_W-1:0] rem_s [QBITS+1];
	logic [SAMPLE_BITS-1:0] den_s [QBITS+1];
	logic [QBITS-1:0] quo_s [QBITS+1];
	logic [2:0] flg_s [QBITS+1];

	always_comb begin
		off = $signed({1'b0, sample}) - $signed({1'b0, center});
		if (off > 0) begin
			span = $signed({1'b0, hi}) - $signed({1'b0, center});
		end else begin
			span = $signed({1'b0, center}) - $signed({1'b0, lo});
		end
		off_abs = off[SAMPLE_BITS] ? -off : off;
		span_abs = span[SAMPLE_BITS] ? -span : span;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_mag_s1 <= off_abs[SAMPLE_BITS-1:0];
			span_mag_s1 <= span_abs[SAMPLE_BITS-1:0];
			zero_s1 <= (off == '0);
			zspan_s1 <= (span == '0);
			// zero span saturates by the offset sign alone
			neg_s1 <= (span == '0) ? off[SAMPLE_BITS] : (off[SAMPLE_BITS] ^ span[SAMPLE_BITS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= MUL_W'(off_mag_s1) * SCALE;
			lim_s2 <= MUL_W'(span_mag_s1) * SAT_LIMIT;
			den_s2 <= span_mag_s1;
			neg_s2 <= neg_s1;
			zero_s2 <= zero_s1;
			zspan_s2 <= zspan_s1;
		end
	end

	// quotient reaches 101 or more: clamp, else it fits in QBITS bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_s2;
			den_s[0] <= den_s2;
			quo_s[0] <= '0;
			flg_s[0] <= {zspan_s2 | (num_s2 >= lim_s2), neg_s2, zero_s2};
		end
	end

	for (genvar i = 0; i < QBITS; i++) begin : g_step
		localparam int SH = QBITS - 1 - i;
		logic [MUL_W-1:0] trial;
		logic take;

		assign trial = MUL_W'(den_s[i]) << SH;
		assign take = (rem_s[i] >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? (rem_s[i] - trial) : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= quo_s[i] | (take ? (QBITS'(1) << SH) : '0);
				flg_s[i+1] <= flg_s[i];
			end
		end
	end

	assign res.sat = flg_s[QBITS][2];
	assign res.neg = flg_s[QBITS][1];
	assign res.zero = flg_s[QBITS][0];
	assign res.mag = quo_s[QBITS];
endmodule
`default_nettype wire

[rtl/jan_dir.sv]
// Result assembly: signed positions, dead-band direction mask and LED byte.
// Depends on jan_pkg.
`default_nettype none
module jan_dir (
	input wire jan_pkg::axis_res_t res_x,
	input wire jan_pkg::axis_res_t res_y,
	input wire logic [jan_pkg::BAND_BITS-1:0] band,
	input wire logic button_level,
	output jan_pkg::out_item_t item
);
	import jan_pkg::*;

	logic [QBITS-1:0] ax, ay;
	logic out_x, out_y;
	logic [4:0] dir;
	logic pressed;

	always_comb begin
		priority if (res_x.zero) begin
			ax = '0;
		end else if (res_x.sat) begin
			ax = FULL_SCALE;
		end else begin
			ax = res_x.mag;
		end
		priority if (res_y.zero) begin
			ay = '0;
		end else if (res_y.sat) begin
			ay = FULL_SCALE;
		end else begin
			ay = res_y.mag;
		end

		out_x = (ax > band);
		out_y = (ay > band);
		dir = '0;
		if (out_x || out_y) begin
			if (out_y && !res_y.neg) dir = dir | DIR_UP;
			if (out_y && res_y.neg) dir = dir | DIR_DOWN;
			if (out_x && !res_x.neg) dir = dir | DIR_RIGHT;
			if (out_x && res_x.neg) dir = dir | DIR_LEFT;
		end else begin
			dir = DIR_CENTER;
		end
		pressed = !button_level;

		item.position_x = res_x.neg ? -$signed({1'b0, ax}) : $signed({1'b0, ax});
		item.position_y = res_y.neg ? -$signed({1'b0, ay}) : $signed({1'b0, ay});
		item.direction_mask = dir;
		item.pressed = pressed;
		item.led_pattern = {3'b000, dir} | (pressed ? LED_BUTTON : 8'h00);
	end
endmodule
`default_nettype wire

[rtl/joystick_axis_normalizer_top.sv]
// Joystick axis normalizer top: calibration registers, pipeline control
// and output register. Depends on jan_pkg, jan_axis, jan_dir.
`default_nettype none
// Takes one X/Y sample pair per cycle while not stalled and returns the scaled
// -100..100 positions, direction mask and LED byte through three stages for
// offset, x100 scale and the clamp test, seven quotient stages (one bit each)
// per axis, and the output register. Back-pressure on the result side stalls
// every stage together; a new transaction is still taken in the cycle the
// held result leaves. Calibration writes are always ready and must only come
// while no transaction is in flight.
module joystick_axis_normalizer_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire jan_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output jan_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [jan_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [jan_pkg::SAMPLE_BITS-1:0] cfg_data
);
	import jan_pkg::*;

	sample_t center_x_q, center_y_q, minimum_x_q, maximum_x_q, minimum_y_q, maximum_y_q;
	logic [BAND_BITS-1:0] dead_band_q;

	logic en;
	logic vld_s [AXIS_LAT];
	logic btn_s [AXIS_LAT];
	axis_res_t res_x, res_y;
	out_item_t item;
	logic out_valid_q;
	out_item_t out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_RST;
			center_y_q <= CENTER_RST;
			minimum_x_q <= MIN_RST;
			maximum_x_q <= MAX_RST;
			minimum_y_q <= MIN_RST;
			maximum_y_q <= MAX_RST;
			dead_band_q <= BAND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_MINIMUM_X: minimum_x_q <= cfg_data;
				CFG_MAXIMUM_X: maximum_x_q <= cfg_data;
				CFG_MINIMUM_Y: minimum_y_q <= cfg_data;
				CFG_MAXIMUM_Y: maximum_y_q <= cfg_data;
				CFG_DEAD_BAND: dead_band_q <= cfg_data[BAND_BITS-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipeline unless a finished result is held
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXIS_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < AXIS_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			btn_s[0] <= in_data.button_level;
			for (int i = 1; i < AXIS_LAT; i++) begin
				btn_s[i] <= btn_s[i-1];
			end
		end
	end

	jan_axis u_axis_x (
		.clk(clk),
		.en(en),
		.sample(in_data.sample_x),
		.center(center_x_q),
		.lo(minimum_x_q),
		.hi(maximum_x_q),
		.res(res_x)
	);

	jan_axis u_axis_y (
		.clk(clk),
		.en(en),
		.sample(in_data.sample_y),
		.center(center_y_q),
		.lo(minimum_y_q),
		.hi(maximum_y_q),
		.res(res_y)
	);

	jan_dir u_dir (
		.res_x(res_x),
		.res_y(res_y),
		.band(dead_band_q),
		.button_level(btn_s[AXIS_LAT-1]),
		.item(item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[AXIS_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
endmodule
`default_nettype wire
